// ===== sv/csrm_pkg.sv =====
// Package for the capture slot ring manager: slot states, result codes,
// operation codes, register indexes and sizes. No dependencies.
package csrm_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CUR_W = $clog2(SLOT_COUNT + 1);
  localparam logic [CUR_W-1:0] NO_SLOT = CUR_W'(SLOT_COUNT);
  localparam logic [16:0] MAX_SLOT_ELEMENTS = 17'd65535;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_FILLING  = 2'd1,
    ST_READY    = 2'd2,
    ST_CONSUMER = 2'd3
  } slot_state_t;

  typedef enum logic [2:0] {
    RS_OK         = 3'd0,
    RS_INVALID    = 3'd1,
    RS_SLOT_READY = 3'd2,
    RS_OVERFLOW   = 3'd3,
    RS_STALE      = 3'd4
  } result_t;

  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_DATA    = 3'd1;
  localparam logic [2:0] OP_ACQUIRE = 3'd2;
  localparam logic [2:0] OP_RELEASE = 3'd3;
  localparam logic [2:0] OP_STOP    = 3'd4;
  localparam logic [2:0] OP_RECOVER = 3'd5;

  localparam logic [0:0] REG_PER_SLOT  = 1'b0;
  localparam logic [0:0] REG_PER_EVENT = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic clear_all;   // config write
    logic load;        // capture input item
    logic scan_reset;  // begin slot scan
    logic scan_step;   // examine one slot
    logic execute;     // apply operation
    logic emit;        // drive result
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
    logic check_busy;  // config divisibility check running
  } ctl_stat_t;

endpackage

// ===== sv/csrm_ctrl.sv =====
// Controller for the capture slot ring manager: sequences load, slot scan,
// execute and result strobe. Depends on csrm_pkg.
module csrm_ctrl import csrm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      cfg_write,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC, S_EMIT} state_t;
  state_t state;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (cmd.load) state <= S_SCAN;
        S_SCAN: if (stat.scan_last) state <= S_EXEC;
        S_EXEC: state <= S_EMIT;
        S_EMIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Commands
  always_comb begin
    cmd = '0;
    cmd.clear_all  = cfg_write;
    cmd.load       = (state == S_IDLE) && start && !stat.check_busy;
    cmd.scan_reset = cmd.load;
    cmd.scan_step  = (state == S_SCAN);
    cmd.execute    = (state == S_EXEC);
    cmd.emit       = (state == S_EMIT);
  end

  // Items wait while an item is in flight or the config check runs
  assign busy = (state != S_IDLE) || stat.check_busy;

  a_emit_after_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> cmd.emit) else $error("emit must follow execute");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.load) else $error("load while busy");
  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_step && stat.scan_last) |=> cmd.execute) else $error("scan end lost");

endmodule

// ===== sv/csrm_datapath.sv =====
// Datapath for the capture slot ring manager: slot registers, counters,
// one-slot-per-cycle scan for free / oldest ready / owned slots. Uses csrm_pkg.
module csrm_datapath import csrm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctl_cmd_t    cmd,
  output ctl_stat_t   stat,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [2:0]  operation,
  input  logic [15:0] element_count,
  input  logic [63:0] time_us,
  input  logic [3:0]  slot_index,
  input  logic [31:0] owner_epoch,
  input  logic [31:0] owner_sequence,
  output logic        done,
  output logic [2:0]  status,
  output logic [1:0]  given_slot,
  output logic [31:0] given_epoch,
  output logic [31:0] given_sequence,
  output logic [63:0] given_start_us,
  output logic [63:0] given_end_us,
  output logic        is_running,
  output logic        is_halted,
  output logic [2:0]  filling_slot,
  output logic [31:0] completed_total,
  output logic [31:0] overflow_total,
  output logic [31:0] recovery_total
);

  // Configuration
  logic [15:0] per_slot, per_event;
  logic        configured;

  // Slot store
  slot_state_t slot_status [SLOT_COUNT];
  logic [15:0] slot_fill [SLOT_COUNT];
  logic [31:0] slot_epoch [SLOT_COUNT];
  logic [31:0] slot_sequence [SLOT_COUNT];
  logic [63:0] slot_start [SLOT_COUNT];
  logic [63:0] slot_end [SLOT_COUNT];

  logic [CUR_W-1:0] current_slot;
  logic [31:0] run_epoch, last_sequence, completed_count, overflow_count, recover_tally;
  logic        run_flag, halt_flag;

  // Latched item
  logic [2:0]  op;
  logic [15:0] cnt;
  logic [63:0] t;
  logic [3:0]  rel_slot;
  logic [31:0] rel_epoch, rel_seq;

  // Scan results
  logic [SLOT_W-1:0] scan_idx;
  logic              free_found, ready_found, owned_any;
  logic [SLOT_W-1:0] free_idx, ready_idx;

  // Result register
  result_t     res_status;
  logic        res_given;
  logic [SLOT_W-1:0] res_slot;

  // Divisibility check: per_event added up until it meets or passes per_slot
  logic        div_ok;
  logic        div_busy;
  logic [15:0] div_acc;
  assign configured = (per_slot != 16'd0) && ({1'b0, per_slot} <= MAX_SLOT_ELEMENTS) &&
                      (per_event != 16'd0) && (per_event <= per_slot) && div_ok;

  assign stat.scan_last  = (scan_idx == SLOT_W'(SLOT_COUNT - 1));
  assign stat.check_busy = div_busy;

  logic [SLOT_W-1:0] cur_idx;
  assign cur_idx = current_slot[SLOT_W-1:0];
  logic cur_valid;
  assign cur_valid = current_slot < NO_SLOT;

  logic [16:0] fill_sum;
  assign fill_sum = {1'b0, slot_fill[cur_idx]} + {1'b0, cnt};

  logic [31:0] seq_inc, ep_inc;
  assign seq_inc = (last_sequence == 32'hFFFF_FFFF) ? 32'd1 : last_sequence + 32'd1;
  assign ep_inc  = (run_epoch == 32'hFFFF_FFFF) ? 32'd1 : run_epoch + 32'd1;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      if (rst) begin
        per_slot  <= '0;
        per_event <= '0;
      end else if (cfg_index == REG_PER_SLOT) begin
        per_slot <= cfg_data;
      end else begin
        per_event <= cfg_data;
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_status[i]   <= ST_FREE;
        slot_fill[i]     <= '0;
        slot_epoch[i]    <= '0;
        slot_sequence[i] <= '0;
        slot_start[i]    <= '0;
        slot_end[i]      <= '0;
      end
      current_slot    <= NO_SLOT;
      run_epoch       <= '0;
      last_sequence   <= '0;
      completed_count <= '0;
      overflow_count  <= '0;
      recover_tally   <= '0;
      run_flag        <= 1'b0;
      halt_flag       <= 1'b0;
      done            <= 1'b0;
      div_busy        <= 1'b1;
      div_acc         <= '0;
      div_ok          <= 1'b0;
      scan_idx        <= '0;
    end else begin
      done <= cmd.emit;
      // Divisibility check: add per_event once per cycle
      if (div_busy) begin
        if (per_event == 16'd0 || per_event > per_slot) begin
          div_ok <= 1'b0;
          div_busy <= 1'b0;
        end else if ({1'b0, div_acc} + {1'b0, per_event} >= {1'b0, per_slot}) begin
          div_ok <= ({1'b0, div_acc} + {1'b0, per_event} == {1'b0, per_slot});
          div_busy <= 1'b0;
        end else begin
          div_acc <= div_acc + per_event;
        end
      end
      if (cmd.load) begin
        op <= operation; cnt <= element_count; t <= time_us;
        rel_slot <= slot_index; rel_epoch <= owner_epoch; rel_seq <= owner_sequence;
        scan_idx <= '0;
        free_found <= 1'b0; ready_found <= 1'b0; owned_any <= 1'b0;
        free_idx <= '0; ready_idx <= '0;
      end
      // One slot per cycle
      if (cmd.scan_step) begin
        if (!free_found && slot_status[scan_idx] == ST_FREE) begin
          free_found <= 1'b1; free_idx <= scan_idx;
        end
        if (slot_status[scan_idx] == ST_READY &&
            (!ready_found || slot_sequence[scan_idx] < slot_sequence[ready_idx])) begin
          ready_found <= 1'b1; ready_idx <= scan_idx;
        end
        if (slot_status[scan_idx] == ST_CONSUMER) owned_any <= 1'b1;
        if (scan_idx != SLOT_W'(SLOT_COUNT - 1)) scan_idx <= scan_idx + SLOT_W'(1);
      end
      if (cmd.execute) begin
        res_given <= (op == OP_ACQUIRE) && ready_found;
        res_slot  <= ready_idx;
        case (op)
          OP_START, OP_RECOVER: begin
            if (!configured || run_flag) begin
              res_status <= RS_INVALID;
            end else if (op == OP_RECOVER && owned_any) begin
              res_status <= RS_STALE;
            end else begin
              // Clear the ring and open slot 0
              for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_status[i]   <= (i == 0) ? ST_FILLING : ST_FREE;
                slot_fill[i]     <= '0;
                slot_epoch[i]    <= (i == 0) ? ep_inc : '0;
                slot_sequence[i] <= '0;
                slot_start[i]    <= (i == 0) ? t : '0;
                slot_end[i]      <= '0;
              end
              current_slot   <= '0;
              run_epoch      <= ep_inc;
              halt_flag      <= 1'b0;
              run_flag       <= 1'b1;
              if (op == OP_RECOVER) recover_tally <= recover_tally + 32'd1;
              res_status <= RS_OK;
            end
          end
          OP_DATA: begin
            if (configured && run_flag && !halt_flag && cur_valid && cnt == per_event &&
                slot_status[cur_idx] == ST_FILLING && t >= slot_start[cur_idx] &&
                fill_sum <= {1'b0, per_slot}) begin
              slot_fill[cur_idx] <= fill_sum[15:0];
              if (fill_sum != {1'b0, per_slot}) begin
                res_status <= RS_OK;
              end else begin
                last_sequence <= seq_inc;
                slot_epoch[cur_idx] <= run_epoch;
                slot_sequence[cur_idx] <= seq_inc;
                slot_end[cur_idx] <= t;
                slot_status[cur_idx] <= ST_READY;
                completed_count <= completed_count + 32'd1;
                // the filling slot was not free during the scan
                if (!free_found) begin
                  current_slot <= NO_SLOT;
                  run_flag <= 1'b0;
                  halt_flag <= 1'b1;
                  overflow_count <= overflow_count + 32'd1;
                  res_status <= RS_OVERFLOW;
                end else begin
                  slot_status[free_idx] <= ST_FILLING;
                  slot_fill[free_idx] <= '0;
                  slot_epoch[free_idx] <= run_epoch;
                  slot_sequence[free_idx] <= '0;
                  slot_start[free_idx] <= t;
                  slot_end[free_idx] <= '0;
                  current_slot <= CUR_W'(free_idx);
                  res_status <= RS_SLOT_READY;
                end
              end
            end else begin
              res_status <= RS_INVALID;
            end
          end
          OP_ACQUIRE: begin
            if (ready_found) begin
              slot_status[ready_idx] <= ST_CONSUMER;
              res_status <= RS_OK;
            end else begin
              res_status <= RS_INVALID;
            end
          end
          OP_RELEASE: begin
            if ({1'b0, rel_slot} < 5'(SLOT_COUNT) &&
                slot_status[rel_slot[SLOT_W-1:0]] == ST_CONSUMER &&
                slot_epoch[rel_slot[SLOT_W-1:0]] == rel_epoch &&
                slot_sequence[rel_slot[SLOT_W-1:0]] == rel_seq) begin
              slot_fill[rel_slot[SLOT_W-1:0]]  <= '0;
              slot_start[rel_slot[SLOT_W-1:0]] <= '0;
              slot_end[rel_slot[SLOT_W-1:0]]   <= '0;
              slot_status[rel_slot[SLOT_W-1:0]] <= ST_FREE;
              res_status <= RS_OK;
            end else begin
              res_status <= RS_STALE;
            end
          end
          OP_STOP: begin
            if (configured) begin
              if (cur_valid && slot_status[cur_idx] == ST_FILLING) begin
                slot_fill[cur_idx] <= '0;
                slot_status[cur_idx] <= ST_FREE;
              end
              current_slot <= NO_SLOT;
              run_flag <= 1'b0;
              res_status <= RS_OK;
            end else begin
              res_status <= RS_INVALID;
            end
          end
          default: res_status <= RS_INVALID;
        endcase
      end
    end
  end

  // Result fields, valid while done is high
  assign status          = res_status;
  assign given_slot      = res_given ? 2'(res_slot) : 2'd0;
  assign given_epoch     = res_given ? slot_epoch[res_slot] : '0;
  assign given_sequence  = res_given ? slot_sequence[res_slot] : '0;
  assign given_start_us  = res_given ? slot_start[res_slot] : '0;
  assign given_end_us    = res_given ? slot_end[res_slot] : '0;
  assign is_running      = run_flag;
  assign is_halted       = halt_flag;
  assign filling_slot    = 3'(current_slot);
  assign completed_total = completed_count;
  assign overflow_total  = overflow_count;
  assign recovery_total  = recover_tally;

  a_run_halt: assert property (@(posedge clk) disable iff (rst)
    !(run_flag && halt_flag)) else $error("running and halted");
  a_run_has_slot: assert property (@(posedge clk) disable iff (rst)
    run_flag |-> cur_valid) else $error("running without filling slot");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> done) else $error("result strobe lost");

endmodule

// ===== sv/capture_slot_ring_manager_unit.sv =====
// Top level of the capture slot ring manager: controller plus datapath.
// Depends on csrm_pkg, csrm_ctrl and csrm_datapath.
//
// An item accepted at one edge goes through the free/ready/owned scan, one
// slot per cycle, then the execute and emit states; its result shows on done,
// registered from the emit state, and cannot be held off. busy drops as done
// rises, so the next item can be accepted while the result shows; a new item
// is not taken before the last one is through. After reset or a configuration
// write the divisibility check of the two registers runs by repeated addition;
// busy stays high and no item is taken meanwhile. Configuration writes are
// taken only while busy is low.
module capture_slot_ring_manager_unit import csrm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [2:0]  operation,
  input  logic [15:0] element_count,
  input  logic [63:0] time_us,
  input  logic [3:0]  slot_index,
  input  logic [31:0] owner_epoch,
  input  logic [31:0] owner_sequence,
  output logic [2:0]  status,
  output logic [1:0]  given_slot,
  output logic [31:0] given_epoch,
  output logic [31:0] given_sequence,
  output logic [63:0] given_start_us,
  output logic [63:0] given_end_us,
  output logic        is_running,
  output logic        is_halted,
  output logic [2:0]  filling_slot,
  output logic [31:0] completed_total,
  output logic [31:0] overflow_total,
  output logic [31:0] recovery_total
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  assign cfg_ready = !busy;

  csrm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start),
    .cfg_write(cfg_valid && cfg_ready), .stat(stat), .cmd(cmd), .busy(busy)
  );

  csrm_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .operation(operation), .element_count(element_count), .time_us(time_us),
    .slot_index(slot_index), .owner_epoch(owner_epoch), .owner_sequence(owner_sequence),
    .done(done), .status(status), .given_slot(given_slot), .given_epoch(given_epoch),
    .given_sequence(given_sequence), .given_start_us(given_start_us),
    .given_end_us(given_end_us), .is_running(is_running), .is_halted(is_halted),
    .filling_slot(filling_slot), .completed_total(completed_total),
    .overflow_total(overflow_total), .recovery_total(recovery_total)
  );

endmodule

// ===== test/tb_capture_slot_ring_manager_unit.sv =====
// Testbench for capture_slot_ring_manager_unit: directed table plus random traffic,
// every result checked against a behavioral slot ring predictor.
// Depends on csrm_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_capture_slot_ring_manager_unit;
  import csrm_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy, done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic [2:0]  operation = '0;
  logic [15:0] element_count = '0;
  logic [63:0] time_us = '0;
  logic [3:0]  slot_index = '0;
  logic [31:0] owner_epoch = '0;
  logic [31:0] owner_sequence = '0;
  logic [2:0]  status;
  logic [1:0]  given_slot;
  logic [31:0] given_epoch, given_sequence;
  logic [63:0] given_start_us, given_end_us;
  logic        is_running, is_halted;
  logic [2:0]  filling_slot;
  logic [31:0] completed_total, overflow_total, recovery_total;

  capture_slot_ring_manager_unit u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct {
    logic [2:0]  st;
    logic [1:0]  gslot;
    logic [31:0] gep, gseq;
    logic [63:0] gstart, gend;
    logic        run, halt;
    logic [2:0]  fill;
    logic [31:0] ncomp, novf, nrec;
  } ring_result_t;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] cnt;
    logic [63:0] t;
    logic [3:0]  idx;
    logic [31:0] ep, sq;
    logic        chk_st;
    logic [2:0]  want_st;
  } ring_cmd_t;

  // Predictor state
  logic [15:0]   per_slot, per_event;
  slot_state_t   s_state [SLOT_COUNT];
  logic [15:0]   s_fill  [SLOT_COUNT];
  logic [31:0]   s_epoch [SLOT_COUNT];
  logic [31:0]   s_seq   [SLOT_COUNT];
  logic [63:0]   s_start [SLOT_COUNT];
  logic [63:0]   s_end   [SLOT_COUNT];
  logic [2:0]    cur;
  logic [31:0]   epoch_ctr, seq_ctr, comp_ctr, ovf_ctr, rec_ctr;
  logic          running, halted;

  ring_result_t  expected_q[$];
  logic [2:0]    want_q[$];
  logic          chk_q[$];
  int            errors = 0;
  int            cycles = 0;
  int            n_items = 0;
  int            st_hist [8];

  function automatic bit ring_configured();
    if (per_slot == 0) return 0;
    if (per_event == 0 || per_event > per_slot) return 0;
    return (per_slot % per_event) == 0;
  endfunction

  function automatic void clear_ring();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      s_state[i] = ST_FREE; s_fill[i] = '0; s_epoch[i] = '0;
      s_seq[i] = '0; s_start[i] = '0; s_end[i] = '0;
    end
    cur = 3'(NO_SLOT);
  endfunction

  function automatic void clear_all_state();
    clear_ring();
    epoch_ctr = '0; seq_ctr = '0; comp_ctr = '0; ovf_ctr = '0; rec_ctr = '0;
    running = 1'b0; halted = 1'b0;
  endfunction

  function automatic void open_slot(int s, logic [63:0] t0);
    s_state[s] = ST_FILLING; s_fill[s] = '0; s_epoch[s] = epoch_ctr;
    s_seq[s] = '0; s_start[s] = t0; s_end[s] = '0; cur = 3'(s);
  endfunction

  function automatic void begin_run(logic [63:0] t0);
    clear_ring();
    epoch_ctr++;
    if (epoch_ctr == 0) epoch_ctr = 1;
    halted = 1'b0; running = 1'b1;
    open_slot(0, t0);
  endfunction

  function automatic result_t apply_data(logic [15:0] cnt, logic [63:0] t);
    int s, nxt;
    if (!ring_configured() || !running || halted || cur >= 3'(NO_SLOT) || cnt != per_event)
      return RS_INVALID;
    s = cur;
    if (s_state[s] != ST_FILLING || t < s_start[s] || cnt > per_slot - s_fill[s])
      return RS_INVALID;
    s_fill[s] += cnt;
    if (s_fill[s] != per_slot) return RS_OK;
    seq_ctr++;
    if (seq_ctr == 0) seq_ctr = 1;
    s_epoch[s] = epoch_ctr; s_seq[s] = seq_ctr; s_end[s] = t;
    s_state[s] = ST_READY;
    comp_ctr++;
    nxt = -1;
    for (int i = SLOT_COUNT - 1; i >= 0; i--)
      if (s_state[i] == ST_FREE) nxt = i;
    if (nxt < 0) begin
      cur = 3'(NO_SLOT); running = 1'b0; halted = 1'b1; ovf_ctr++;
      return RS_OVERFLOW;
    end
    open_slot(nxt, t);
    return RS_SLOT_READY;
  endfunction

  function automatic ring_result_t predict_ring(ring_cmd_t c);
    ring_result_t r;
    int sel;
    bit owned;
    r = '{default: '0};
    r.st = RS_INVALID;
    case (c.op)
      OP_START: if (ring_configured() && !running) begin
        begin_run(c.t); r.st = RS_OK;
      end
      OP_DATA: r.st = apply_data(c.cnt, c.t);
      OP_ACQUIRE: begin
        sel = -1;
        for (int i = 0; i < SLOT_COUNT; i++)
          if (s_state[i] == ST_READY && (sel < 0 || s_seq[i] < s_seq[sel])) sel = i;
        if (sel >= 0) begin
          s_state[sel] = ST_CONSUMER;
          r.gslot = 2'(sel); r.gep = s_epoch[sel]; r.gseq = s_seq[sel];
          r.gstart = s_start[sel]; r.gend = s_end[sel]; r.st = RS_OK;
        end
      end
      OP_RELEASE: begin
        r.st = RS_STALE;
        if (c.idx < SLOT_COUNT && s_state[c.idx] == ST_CONSUMER &&
            s_epoch[c.idx] == c.ep && s_seq[c.idx] == c.sq) begin
          s_fill[c.idx] = '0; s_start[c.idx] = '0; s_end[c.idx] = '0;
          s_state[c.idx] = ST_FREE; r.st = RS_OK;
        end
      end
      OP_STOP: if (ring_configured()) begin
        if (cur < 3'(NO_SLOT) && s_state[cur] == ST_FILLING) begin
          s_fill[cur] = '0; s_state[cur] = ST_FREE;
        end
        cur = 3'(NO_SLOT); running = 1'b0; r.st = RS_OK;
      end
      OP_RECOVER: if (ring_configured() && !running) begin
        owned = 0;
        for (int i = 0; i < SLOT_COUNT; i++) if (s_state[i] == ST_CONSUMER) owned = 1;
        if (owned) r.st = RS_STALE;
        else begin
          begin_run(c.t); rec_ctr++; r.st = RS_OK;
        end
      end
      default: ;
    endcase
    r.run = running; r.halt = halted; r.fill = cur;
    r.ncomp = comp_ctr; r.novf = ovf_ctr; r.nrec = rec_ctr;
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    ring_result_t e;
    logic [2:0] w;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result with no expectation, status %0d", status);
        errors++;
      end else begin
        e = expected_q.pop_front();
        w = want_q.pop_front();
        if (chk_q.pop_front() && w != status) begin
          $error("status (table): expected %0d actual %0d", w, status);
          errors++;
        end
        st_hist[status]++;
        if (status !== e.st) begin
          $error("status: expected %0d actual %0d", e.st, status); errors++; end
        if (given_slot !== e.gslot) begin
          $error("given_slot: expected %0d actual %0d", e.gslot, given_slot); errors++; end
        if (given_epoch !== e.gep) begin
          $error("given_epoch: expected %0h actual %0h", e.gep, given_epoch); errors++; end
        if (given_sequence !== e.gseq) begin
          $error("given_sequence: expected %0h actual %0h", e.gseq, given_sequence);
          errors++;
        end
        if (given_start_us !== e.gstart) begin
          $error("given_start_us: expected %0h actual %0h", e.gstart, given_start_us);
          errors++;
        end
        if (given_end_us !== e.gend) begin
          $error("given_end_us: expected %0h actual %0h", e.gend, given_end_us); errors++; end
        if (is_running !== e.run) begin
          $error("is_running: expected %0d actual %0d", e.run, is_running); errors++; end
        if (is_halted !== e.halt) begin
          $error("is_halted: expected %0d actual %0d", e.halt, is_halted); errors++; end
        if (filling_slot !== e.fill) begin
          $error("filling_slot: expected %0d actual %0d", e.fill, filling_slot); errors++; end
        if (completed_total !== e.ncomp) begin
          $error("completed_total: expected %0d actual %0d", e.ncomp, completed_total);
          errors++;
        end
        if (overflow_total !== e.novf) begin
          $error("overflow_total: expected %0d actual %0d", e.novf, overflow_total);
          errors++;
        end
        if (recovery_total !== e.nrec) begin
          $error("recovery_total: expected %0d actual %0d", e.nrec, recovery_total);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  // Called at a falling edge; busy only moves at rising edges
  task automatic send_item(ring_cmd_t c);
    wait_cycles($urandom_range(0, 13) * ($urandom_range(0, 3) != 0));
    operation = c.op; element_count = c.cnt; time_us = c.t;
    slot_index = c.idx; owner_epoch = c.ep; owner_sequence = c.sq;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    expected_q.push_back(predict_ring(c));
    want_q.push_back(c.want_st);
    chk_q.push_back(c.chk_st);
    n_items++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(negedge clk);
    wait_cycles(10);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    drain_results();
    cfg_index = idx; cfg_data = val; cfg_valid = 1'b1;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    if (idx == REG_PER_SLOT) per_slot = val; else per_event = val;
    clear_all_state();
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic ring_cmd_t mk(logic [2:0] op, logic [15:0] cnt = 0,
                                   logic [63:0] t = 0, logic [3:0] idx = 0,
                                   logic [31:0] ep = 0, logic [31:0] sq = 0,
                                   logic chk = 0, logic [2:0] w = 0);
    ring_cmd_t c;
    c.op = op; c.cnt = cnt; c.t = t; c.idx = idx; c.ep = ep; c.sq = sq;
    c.chk_st = chk; c.want_st = w;
    return c;
  endfunction

  // Random item biased toward well-formed traffic
  function automatic ring_cmd_t rand_item();
    ring_cmd_t c;
    int k, s;
    c = mk(3'($urandom_range(0, 7)), 16'($urandom), {$urandom, $urandom},
           4'($urandom), $urandom, $urandom);
    k = $urandom_range(0, 99);
    if (k < 45) begin
      c.op = OP_DATA; c.cnt = per_event;
      c.t = (cur < 3'(NO_SLOT)) ? s_start[cur] + $urandom_range(0, 1000) : c.t;
      if ($urandom_range(0, 30) == 0) c.t = {$urandom, $urandom};
    end else if (k < 60) c.op = OP_ACQUIRE;
    else if (k < 75) begin
      c.op = OP_RELEASE; s = $urandom_range(0, SLOT_COUNT - 1);
      c.idx = 4'(s); c.ep = s_epoch[s]; c.sq = s_seq[s];
      if ($urandom_range(0, 5) == 0) c.sq ^= 32'(1) << $urandom_range(0, 31);
      if ($urandom_range(0, 5) == 0) c.ep ^= 32'(1) << $urandom_range(0, 31);
    end else if (k < 82) c.op = OP_RECOVER;
    else if (k < 88) c.op = OP_START;
    else if (k < 92) c.op = OP_STOP;
    return c;
  endfunction

  ring_cmd_t dir_tab[$];
  logic [15:0] cfg_sets[6][2] = '{'{16'd4, 16'd1}, '{16'd8, 16'd4}, '{16'd3, 16'd3},
                                  '{16'd65535, 16'd65535}, '{16'd6, 16'd4},
                                  '{16'd12, 16'd3}};

  initial begin
    clear_all_state();
    per_slot = '0; per_event = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Unconfigured: start, data, acquire, stop, recover invalid; bad ops; stale release
    dir_tab = '{mk(OP_START, 0, 0, 0, 0, 0, 1, RS_INVALID),
                mk(OP_DATA, 1, 5, 0, 0, 0, 1, RS_INVALID),
                mk(OP_ACQUIRE, 0, 0, 0, 0, 0, 1, RS_INVALID),
                mk(OP_RELEASE, 0, 0, 4'hF, '1, '1, 1, RS_STALE),
                mk(OP_STOP, 0, 0, 0, 0, 0, 1, RS_INVALID),
                mk(OP_RECOVER, 0, 0, 0, 0, 0, 1, RS_INVALID),
                mk(3'd6, 0, 0, 0, 0, 0, 1, RS_INVALID),
                mk(3'd7, '1, '1, 0, 0, 0, 1, RS_INVALID)};
    foreach (dir_tab[i]) send_item(dir_tab[i]);

    // Configured 2/1: fill all four slots to overflow, then recover paths
    write_reg(REG_PER_SLOT, 16'd2);
    write_reg(REG_PER_EVENT, 16'd1);
    dir_tab = '{mk(OP_START, 0, 64'd100, 0, 0, 0, 1, RS_OK),
                mk(OP_START, 0, 64'd100, 0, 0, 0, 1, RS_INVALID),
                mk(OP_DATA, 2, 64'd200, 0, 0, 0, 1, RS_INVALID),
                mk(OP_DATA, 1, 64'd99, 0, 0, 0, 1, RS_INVALID),
                mk(OP_DATA, 1, 64'd100), mk(OP_DATA, 1, 64'd150),
                mk(OP_DATA, 1, 64'd160), mk(OP_DATA, 1, 64'd170),
                mk(OP_DATA, 1, 64'd180), mk(OP_DATA, 1, 64'd190),
                mk(OP_DATA, 1, 64'd200), mk(OP_DATA, 1, '1),
                mk(OP_DATA, 1, '1, 0, 0, 0, 1, RS_INVALID),
                mk(OP_ACQUIRE), mk(OP_RECOVER, 0, 64'd5, 0, 0, 0, 1, RS_STALE),
                mk(OP_RELEASE, 0, 0, 0, 1, 1), mk(OP_RECOVER, 0, '1),
                mk(OP_STOP, 0, 0, 0, 0, 0, 1, RS_OK)};
    foreach (dir_tab[i]) send_item(dir_tab[i]);

    // Random phases across settings, extremes and unconfigured cases
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 6) begin
        write_reg(REG_PER_SLOT, cfg_sets[ph][0]);
        write_reg(REG_PER_EVENT, cfg_sets[ph][1]);
      end else if (ph == 6) write_reg(REG_PER_EVENT, 16'd0);
      else begin
        write_reg(REG_PER_SLOT, 16'($urandom_range(1, 8) * 2));
        write_reg(REG_PER_EVENT, $urandom_range(0, 1) ? 16'd2 : 16'd1);
      end
      if (ph == 3) begin
        // Cheap element coverage at the widest setting
        send_item(mk(OP_START, 0, 0));
        send_item(mk(OP_DATA, 16'hFFFF, 64'd1));
        send_item(mk(OP_DATA, 16'h0000, 64'd1));
      end else begin
        send_item(mk(OP_START, 0, {$urandom, $urandom} >> $urandom_range(0, 63)));
        for (int j = 0; j < 74; j++) begin
          send_item(rand_item());
          if (j == 35) drain_results();
        end
      end
    end

    drain_results();
    $display("Ran %0d items over 12 register settings: ok %0d invalid %0d ready %0d",
             n_items, st_hist[RS_OK], st_hist[RS_INVALID], st_hist[RS_SLOT_READY]);
    $display("overflow %0d stale %0d results", st_hist[RS_OVERFLOW], st_hist[RS_STALE]);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
sv/csrm_pkg.sv
sv/csrm_ctrl.sv
sv/csrm_datapath.sv
sv/capture_slot_ring_manager_unit.sv
test/tb_capture_slot_ring_manager_unit.sv
